>>> hdl/memory_size_unit_normalizer_core_macros.svh
// Assertion macros used by the memory size unit normalizer checker.
// Depends on a clk and an active-high rst in the scope where a macro is used.
`ifndef MEMORY_SIZE_UNIT_NORMALIZER_CORE_MACROS_SVH
`define MEMORY_SIZE_UNIT_NORMALIZER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MSUN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MSUN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/msun_pkg.sv
// Types, constants and the microcode program of the memory size unit normalizer.
// No dependencies; used by the sequencer, the top level and the checker.
package msun_pkg;

  localparam int unsigned UNIT_SHIFT = 10;
  localparam int unsigned UNIT_STEP  = 1 << UNIT_SHIFT;
  localparam int unsigned WORD_W     = 32;

  // Divider: restoring, one quotient bit per step
  localparam int unsigned DIVISOR_W  = UNIT_SHIFT + 1;
  localparam int unsigned PER_STEPS  = UNIT_SHIFT + 1;
  localparam int unsigned CNT_STEPS  = WORD_W;
  localparam int unsigned LOOP_W     = $clog2(CNT_STEPS + 1);
  localparam logic [WORD_W-1:0] PER_DIVIDEND =
    WORD_W'(UNIT_STEP) << (WORD_W - PER_STEPS);

  typedef enum logic [1:0] {
    UNIT_BYTE = 2'd0,
    UNIT_KIB  = 2'd1,
    UNIT_MIB  = 2'd2,
    UNIT_GIB  = 2'd3
  } size_unit_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_TOTAL,
    OP_SET_KIB,
    OP_DIV_PER_INIT,
    OP_DIV_STEP,
    OP_DIV_CNT_INIT,
    OP_DIV_DONE,
    OP_MUL_SCALE,
    OP_NORM,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_ZERO_SIZE,
    COND_NO_OVF,
    COND_BIG_BLOCK,
    COND_LOOP_BUSY,
    COND_NORM_MORE,
    COND_OUT_BUSY
  } cond_t;

  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // Program addresses
  localparam pc_t STEP_IDLE      = 4'd0;
  localparam pc_t STEP_TOTAL     = 4'd1;
  localparam pc_t STEP_OVF_CHECK = 4'd2;
  localparam pc_t STEP_KIB       = 4'd3;
  localparam pc_t STEP_PER_INIT  = 4'd4;
  localparam pc_t STEP_PER_DIV   = 4'd5;
  localparam pc_t STEP_CNT_INIT  = 4'd6;
  localparam pc_t STEP_CNT_DIV   = 4'd7;
  localparam pc_t STEP_DIV_DONE  = 4'd8;
  localparam pc_t STEP_SCALE     = 4'd9;
  localparam pc_t STEP_NORM      = 4'd10;
  localparam pc_t STEP_WAIT_OUT  = 4'd11;
  localparam pc_t STEP_EMIT      = 4'd12;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctl_word_t;

  typedef struct packed {
    logic in_valid;
    logic zero_size;
    logic no_ovf;
    logic big_block;
    logic loop_busy;
    logic norm_more;
    logic out_busy;
  } seq_status_t;

  // Control store: jump to target when the condition holds, else fall through
  function automatic ctl_word_t ucode_rom(pc_t addr);
    ctl_word_t cw;
    unique case (addr)
      STEP_IDLE:      cw = '{OP_LOAD,         COND_NO_INPUT,  STEP_IDLE};
      STEP_TOTAL:     cw = '{OP_MUL_TOTAL,    COND_ZERO_SIZE, STEP_WAIT_OUT};
      STEP_OVF_CHECK: cw = '{OP_NOP,          COND_NO_OVF,    STEP_NORM};
      STEP_KIB:       cw = '{OP_SET_KIB,      COND_BIG_BLOCK, STEP_SCALE};
      STEP_PER_INIT:  cw = '{OP_DIV_PER_INIT, COND_NEVER,     STEP_IDLE};
      STEP_PER_DIV:   cw = '{OP_DIV_STEP,     COND_LOOP_BUSY, STEP_PER_DIV};
      STEP_CNT_INIT:  cw = '{OP_DIV_CNT_INIT, COND_NEVER,     STEP_IDLE};
      STEP_CNT_DIV:   cw = '{OP_DIV_STEP,     COND_LOOP_BUSY, STEP_CNT_DIV};
      STEP_DIV_DONE:  cw = '{OP_DIV_DONE,     COND_ALWAYS,    STEP_NORM};
      STEP_SCALE:     cw = '{OP_MUL_SCALE,    COND_NEVER,     STEP_IDLE};
      STEP_NORM:      cw = '{OP_NORM,         COND_NORM_MORE, STEP_NORM};
      STEP_WAIT_OUT:  cw = '{OP_NOP,          COND_OUT_BUSY,  STEP_WAIT_OUT};
      STEP_EMIT:      cw = '{OP_EMIT,         COND_ALWAYS,    STEP_IDLE};
      default:        cw = '{OP_NOP,          COND_ALWAYS,    STEP_IDLE};
    endcase
    return cw;
  endfunction

endpackage

>>> hdl/msun_in_if.sv
// Input channel of the memory size unit normalizer: block count and block size.
// No dependencies.
interface msun_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_count;
  logic [31:0] block_size;

  modport source (output valid, output block_count, output block_size, input ready);
  modport sink   (input valid, input block_count, input block_size, output ready);
endinterface

>>> hdl/msun_out_if.sv
// Result channel of the memory size unit normalizer.
// No dependencies.
interface msun_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  size_unit;
  logic [11:0] whole_count;
  logic [9:0]  fraction;
  logic        size_error;

  modport source (output valid, output size_unit, output whole_count,
                  output fraction, output size_error, input ready);
  modport sink   (input valid, input size_unit, input whole_count,
                  input fraction, input size_error, output ready);
endinterface

>>> hdl/msun_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on msun_pkg.
module msun_seq
  import msun_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  seq_status_t status,
  output ctl_word_t   ctl
);

  pc_t  pc;
  pc_t  pc_next;
  logic jump;

  // Fetch the current control word
  assign ctl = ucode_rom(pc);

  // Evaluate the jump condition
  always_comb begin
    unique case (ctl.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NO_INPUT:  jump = !status.in_valid;
      COND_ZERO_SIZE: jump = status.zero_size;
      COND_NO_OVF:    jump = status.no_ovf;
      COND_BIG_BLOCK: jump = status.big_block;
      COND_LOOP_BUSY: jump = status.loop_busy;
      COND_NORM_MORE: jump = status.norm_more;
      COND_OUT_BUSY:  jump = status.out_busy;
      default:        jump = 1'b1;
    endcase
  end

  // Jump or fall through
  assign pc_next = jump ? ctl.target : pc + pc_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> hdl/memory_size_unit_normalizer_core.sv
// Paths: a zero block size, a byte total that fits in 32 bits, an overflowing total with
// a block of 1 KiB or more, and a count divided in KiB (11 divider steps for 1024/size,
// 32 for the count). A new result waits in STEP_WAIT_OUT while the last is not taken.
// One transaction at a time: input is taken only in the idle step; a waiting result does
// not block the next input. Synchronous reset returns the sequencer to idle and
// empties the output register.
module memory_size_unit_normalizer_core
  import msun_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  msun_in_if.sink     blocks,
  msun_out_if.source  result
);

  ctl_word_t   ctl;
  seq_status_t status;

  // Operand and working registers
  logic [WORD_W-1:0]    cnt;
  logic [WORD_W-1:0]    bsz;
  logic [WORD_W-1:0]    acc;
  logic [UNIT_SHIFT-1:0] frac;
  size_unit_t           unit;
  logic                 ovf;
  logic [WORD_W-1:0]    dq;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] divisor;
  logic [LOOP_W-1:0]    loop;

  // Output register
  logic        out_valid;
  size_unit_t  out_unit;
  logic [11:0] out_whole;
  logic [9:0]  out_frac;
  logic        out_error;

  logic [WORD_W-1:0]   mul_b;
  logic [2*WORD_W-1:0] prod;
  logic [DIVISOR_W:0]  rem_sh;
  logic                q_bit;
  logic [DIVISOR_W:0]  rem_new;

  msun_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl)
  );

  // Shared multiplier: full byte total or count times size in KiB
  assign mul_b = (ctl.op == OP_MUL_SCALE) ?
                 {{UNIT_SHIFT{1'b0}}, bsz[WORD_W-1:UNIT_SHIFT]} : bsz;
  assign prod  = cnt * mul_b;

  // One restoring division step
  assign rem_sh  = {rem, dq[WORD_W-1]};
  assign q_bit   = rem_sh >= {1'b0, divisor};
  assign rem_new = q_bit ? rem_sh - {1'b0, divisor} : rem_sh;

  // Status back to the sequencer
  assign status.in_valid  = blocks.valid;
  assign status.zero_size = (bsz == '0);
  assign status.no_ovf    = !ovf;
  assign status.big_block = |bsz[WORD_W-1:UNIT_SHIFT];
  assign status.loop_busy = (loop != LOOP_W'(1));
  assign status.norm_more = (acc >= WORD_W'(UNIT_STEP)) && (unit != UNIT_GIB);
  assign status.out_busy  = out_valid && !result.ready;

  assign blocks.ready = (ctl.op == OP_LOAD);

  // Datapath registers, driven by the control word
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        if (blocks.valid) begin
          cnt <= blocks.block_count;
          bsz <= blocks.block_size;
        end
      end
      OP_MUL_TOTAL: begin
        acc  <= prod[WORD_W-1:0];
        ovf  <= |prod[2*WORD_W-1:WORD_W];
        unit <= UNIT_BYTE;
        frac <= '0;
      end
      OP_SET_KIB: begin
        unit <= UNIT_KIB;
        frac <= '0;
      end
      OP_DIV_PER_INIT: begin
        dq      <= PER_DIVIDEND;
        rem     <= '0;
        divisor <= {1'b0, bsz[UNIT_SHIFT-1:0]};
        loop    <= LOOP_W'(PER_STEPS);
      end
      OP_DIV_STEP: begin
        dq   <= {dq[WORD_W-2:0], q_bit};
        rem  <= rem_new[DIVISOR_W-1:0];
        loop <= loop - LOOP_W'(1);
      end
      OP_DIV_CNT_INIT: begin
        divisor <= dq[DIVISOR_W-1:0];
        dq      <= cnt;
        rem     <= '0;
        loop    <= LOOP_W'(CNT_STEPS);
      end
      OP_DIV_DONE: begin
        acc  <= dq;
        frac <= rem[UNIT_SHIFT-1:0];
      end
      OP_MUL_SCALE: begin
        acc <= prod[WORD_W-1:0];
      end
      OP_NORM: begin
        if (status.norm_more) begin
          frac <= acc[UNIT_SHIFT-1:0];
          acc  <= acc >> UNIT_SHIFT;
          unit <= size_unit_t'(unit + 2'd1);
        end
      end
      OP_NOP, OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // Output register: load on emit, drop when the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_EMIT) begin
      out_unit  <= unit;
      out_whole <= acc[11:0];
      out_frac  <= frac;
      out_error <= (bsz == '0);
    end
  end

  assign result.valid       = out_valid;
  assign result.size_unit   = out_unit;
  assign result.whole_count = out_whole;
  assign result.fraction    = out_frac;
  assign result.size_error  = out_error;

endmodule

>>> hdl/msun_checker.sv
// Port-level checks for the memory size unit normalizer and their bind.
// Depends on msun_pkg and memory_size_unit_normalizer_core_macros.svh.
`include "memory_size_unit_normalizer_core_macros.svh"

module msun_checker
  import msun_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_unit,
  input logic [11:0] out_whole,
  input logic [9:0]  out_frac,
  input logic        out_error
);

  // Hold a stalled result
  `MSUN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_unit) && $stable(out_whole) && $stable(out_frac) && $stable(out_error), "stalled result changed")

  // Zero block size reports nothing but the flag
  `MSUN_ASSERT_NOW(a_error_clean, out_valid && out_error, out_unit == 2'd0 && out_whole == 12'd0 && out_frac == 10'd0, "error result carries data")

  // Below GiB the whole amount stays under one unit step
  `MSUN_ASSERT_NOW(a_whole_range, out_valid && !out_error && out_unit != UNIT_GIB, out_whole < 12'(UNIT_STEP), "whole count not normalized")

  // One transaction at a time: busy right after an accept
  `MSUN_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted back to back")

endmodule

bind memory_size_unit_normalizer_core msun_checker u_msun_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (blocks.valid),
  .in_ready  (blocks.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_unit  (result.size_unit),
  .out_whole (result.whole_count),
  .out_frac  (result.fraction),
  .out_error (result.size_error)
);

>>> tb/sv/tb.sv
// Self-checking bench for memory_size_unit_normalizer_core: directed table, then random.
// Depends on msun_pkg, msun_in_if, msun_out_if and the core RTL.
module tb;
  import msun_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned QUIET_ITEMS  = 150;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT  = 600_000;

  typedef struct packed {
    size_unit_t  unit;
    logic [11:0] whole;
    logic [9:0]  frac;
    logic        err;
  } size_result_t;

  typedef struct packed {
    logic [31:0]  cnt;
    logic [31:0]  sz;
    bit           typed;
    size_result_t want;
  } blocks_row_t;

  localparam size_result_t NONE     = '{UNIT_BYTE, 12'd0, 10'd0, 1'b0};
  localparam size_result_t ZERO_ERR = '{UNIT_BYTE, 12'd0, 10'd0, 1'b1};

  localparam int unsigned N_ROWS = 23;
  localparam blocks_row_t DIRECTED_ROWS [N_ROWS] = '{
    // zero block size
    '{32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_ERR},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ZERO_ERR},
    // byte range and the first step up
    '{32'h0000_0000, 32'h0000_0001, 1'b1, NONE},
    '{32'h0000_0001, 32'h0000_0001, 1'b1, '{UNIT_BYTE, 12'd1, 10'd0, 1'b0}},
    '{32'h0000_03FF, 32'h0000_0001, 1'b1, '{UNIT_BYTE, 12'd1023, 10'd0, 1'b0}},
    '{32'h0000_0400, 32'h0000_0001, 1'b1, '{UNIT_KIB, 12'd1, 10'd0, 1'b0}},
    '{32'h0000_0001, 32'h0000_03FF, 1'b1, '{UNIT_BYTE, 12'd1023, 10'd0, 1'b0}},
    '{32'h0000_0001, 32'h0000_0400, 1'b1, '{UNIT_KIB, 12'd1, 10'd0, 1'b0}},
    // full 32-bit byte total
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{UNIT_GIB, 12'd3, 10'd1023, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{UNIT_GIB, 12'd3, 10'd1023, 1'b0}},
    // KiB start, GiB amount of 1024 or more
    '{32'hFFFF_FFFF, 32'h0000_0400, 1'b1, '{UNIT_GIB, 12'd4095, 10'd1023, 1'b0}},
    // KiB start, product wraps to zero, then mixed rows checked against normalize_size
    '{32'h0040_0000, 32'h0040_0000, 1'b1, '{UNIT_KIB, 12'd0, 10'd0, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NONE},
    '{32'hFFFF_FFFF, 32'h0000_0002, 1'b0, NONE},
    '{32'hFFFF_FFFF, 32'h0000_03FF, 1'b0, NONE},
    '{32'h8000_0000, 32'h0000_0003, 1'b0, NONE},
    '{32'h0001_0000, 32'h0001_0000, 1'b0, NONE},
    '{32'h0000_0003, 32'h5555_5555, 1'b0, NONE},
    '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, NONE},
    '{32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0, NONE},
    // overflow boundary for a 1023-byte block, then two 2 GiB blocks
    '{32'h0040_1004, 32'h0000_03FF, 1'b0, NONE},
    '{32'h0040_1005, 32'h0000_03FF, 1'b0, NONE},
    '{32'h0000_0002, 32'h8000_0000, 1'b0, NONE}
  };

  logic clk = 1'b0;
  logic rst;
  bit   quiet;
  int unsigned cycles;
  int unsigned mismatches;

  size_result_t owed_sizes [$];
  blocks_row_t  table_wants [$];

  msun_in_if  blk_ch ();
  msun_out_if res_ch ();

  memory_size_unit_normalizer_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .blocks (blk_ch),
    .result (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute the expected size from one block count and block size.
  function automatic size_result_t normalize_size(logic [31:0] cnt, logic [31:0] sz);
    size_result_t r;
    logic [31:0]  amount;
    logic [31:0]  rem;
    logic [31:0]  per;
    logic [1:0]   u;
    r = NONE;
    rem = '0;
    if (sz == 32'd0) begin
      r.err = 1'b1;
      return r;
    end
    if (cnt > 32'hFFFF_FFFF / sz) begin
      // byte total overflows: start in KiB
      u = UNIT_KIB;
      if (sz < UNIT_STEP) begin
        per = UNIT_STEP / sz;
        rem = cnt % per;
        amount = cnt / per;
      end else begin
        amount = cnt * (sz >> UNIT_SHIFT);
      end
    end else begin
      u = UNIT_BYTE;
      amount = cnt * sz;
    end
    // step up while the amount is too big, stopping at GiB
    if (amount >= UNIT_STEP) begin
      do begin
        rem = amount % UNIT_STEP;
        amount = amount / UNIT_STEP;
        u = u + 2'd1;
      end while (amount >= UNIT_STEP && u != UNIT_GIB);
    end
    r.unit  = size_unit_t'(u);
    r.whole = amount[11:0];
    r.frac  = rem[9:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_block_size();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 3) return 32'd0;
    if (sel < 33) return 32'($urandom_range(1, 1023));
    if (sel < 48) return 32'd1 << $urandom_range(0, 31);
    if (sel < 58) return 32'($urandom_range(1024, 1 << 20));
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_block_count(logic [31:0] sz);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 4) return 32'($urandom_range(0, 4095));
    if (sel == 5) return 32'hFFFF_FFFF >> $urandom_range(0, 31);
    // hug the overflow boundary
    if (sel >= 6 && sel <= 7 && sz != 32'd0)
      return 32'hFFFF_FFFF / sz - 32'd2 + 32'($urandom_range(0, 4));
    return $urandom();
  endfunction

  // Offer one transaction; entered and left at a falling edge.
  task automatic offer_blocks(input blocks_row_t row);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      blk_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    blk_ch.valid       <= 1'b1;
    blk_ch.block_count <= row.cnt;
    blk_ch.block_size  <= row.sz;
    table_wants.push_back(row);
    do @(posedge clk); while (!blk_ch.ready);
    @(negedge clk);
  endtask

  // Hold result ready low in random bursts, none in the quiet tail.
  initial begin
    int unsigned stall;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 11);
        res_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Predict on input transactions, compare on output transactions.
  always @(posedge clk) begin
    blocks_row_t  row;
    size_result_t want;
    size_result_t got;
    if (!rst && blk_ch.valid && blk_ch.ready) begin
      row = table_wants.pop_front();
      want = row.typed ? row.want : normalize_size(blk_ch.block_count, blk_ch.block_size);
      owed_sizes.push_back(want);
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{size_unit_t'(res_ch.size_unit), res_ch.whole_count, res_ch.fraction,
              res_ch.size_error};
      if (owed_sizes.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatches++;
      end else begin
        want = owed_sizes.pop_front();
        if (got.unit !== want.unit) begin
          $error("size_unit: expected %0d, got %0d", want.unit, got.unit);
          mismatches++;
        end
        if (got.whole !== want.whole) begin
          $error("whole_count: expected %0d, got %0d", want.whole, got.whole);
          mismatches++;
        end
        if (got.frac !== want.frac) begin
          $error("fraction: expected %0d, got %0d", want.frac, got.frac);
          mismatches++;
        end
        if (got.err !== want.err) begin
          $error("size_error: expected %0d, got %0d", want.err, got.err);
          mismatches++;
        end
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    blocks_row_t row;
    rst = 1'b1;
    quiet = 1'b0;
    blk_ch.valid = 1'b0;
    blk_ch.block_count = '0;
    blk_ch.block_size = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (int i = 0; i < N_ROWS; i++) offer_blocks(DIRECTED_ROWS[i]);

    // random items, quiet tail with no idling
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      row.sz = pick_block_size();
      row.cnt = pick_block_count(row.sz);
      row.typed = 1'b0;
      row.want = NONE;
      offer_blocks(row);
    end
    blk_ch.valid <= 1'b0;

    // drain
    while (owed_sizes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && owed_sizes.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
